// ===== hdl/acs_pkg.sv =====
`default_nettype none

package acs_pkg;

  // default word memory address width
  localparam int MemAddrBitsDef = 10;

  // queue depths (powers of two)
  localparam int CmdqDepth = 2;
  localparam int CmdqPtrW  = $clog2(CmdqDepth);
  localparam int CmdqCntW  = $clog2(CmdqDepth + 1);
  localparam int ResqDepth = 2;
  localparam int ResqPtrW  = $clog2(ResqDepth);
  localparam int ResqCntW  = $clog2(ResqDepth + 1);

  // instruction opcodes, bits 2:0
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_STORE = 3'd2;
  localparam logic [2:0] OP_BRZ   = 3'd3;
  localparam logic [2:0] OP_COPY  = 3'd4;

  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_HOST = 1'b1;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_ADD,
    ACT_STORE,
    ACT_BRZ,
    ACT_COPY,
    ACT_HOST
  } act_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_ISSUE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] instr;
    logic [9:0]  host_addr;
    logic [15:0] host_data;
  } in_word_t;

  typedef struct packed {
    logic [15:0] prog_counter;
    logic [15:0] accum;
    logic        copy_phase;
    logic [15:0] copy_offset;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    act_e        act;
    logic [7:0]  addr;
    logic [5:0]  src;
    logic [6:0]  dst;
    logic [9:0]  host_addr;
    logic [15:0] host_data;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic issue;
  } back_status_t;

endpackage

`default_nettype wire

// ===== hdl/acs_front.sv =====
`default_nettype none

module acs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  acs_pkg::in_word_t in_word_i,
  output logic             full_o,
  input  logic             take_i,
  output logic             avail_o,
  output acs_pkg::cmd_t    cmd_o
);
  import acs_pkg::*;

  cmd_t                cmd_dec;
  cmd_t                q_q [CmdqDepth];
  logic [CmdqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdqCntW-1:0] cnt_q, cnt_d;

  // classify the word
  always_comb begin
    cmd_dec.addr      = in_word_i.instr[15:8];
    cmd_dec.src       = in_word_i.instr[8:3];
    cmd_dec.dst       = in_word_i.instr[15:9];
    cmd_dec.host_addr = in_word_i.host_addr;
    cmd_dec.host_data = in_word_i.host_data;
    if (in_word_i.kind == KIND_HOST) begin
      cmd_dec.act = ACT_HOST;
    end else begin
      unique case (in_word_i.instr[2:0])
        OP_LOAD:  cmd_dec.act = ACT_LOAD;
        OP_ADD:   cmd_dec.act = ACT_ADD;
        OP_STORE: cmd_dec.act = ACT_STORE;
        OP_BRZ:   cmd_dec.act = ACT_BRZ;
        OP_COPY:  cmd_dec.act = ACT_COPY;
        default:  cmd_dec.act = ACT_NOP;
      endcase
    end
  end

  assign full_o  = (cnt_q == CmdqCntW'(CmdqDepth));
  assign avail_o = (cnt_q != '0);
  assign cmd_o   = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = take_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CmdqCntW'(push_i) - CmdqCntW'(take_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_ptr_q] <= cmd_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/acs_back.sv =====
`default_nettype none

module acs_back #(
  parameter int MemAddrBits = acs_pkg::MemAddrBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_avail_i,
  input  acs_pkg::cmd_t         cmd_i,
  output logic                  cmd_take_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output acs_pkg::out_word_t    res_word_o,
  output acs_pkg::back_status_t status_o
);
  import acs_pkg::*;

  localparam int MemDepth = 1 << MemAddrBits;

  back_state_e           state_q, state_d;
  cmd_t                  cur_q, cur_d;
  logic [15:0]           acc_q, acc_d;
  logic [15:0]           pc_q, pc_d;
  logic                  phase_q, phase_d;
  logic [15:0]           held_q, held_d;
  logic [15:0]           offset_q, offset_d;
  logic [MemAddrBits-1:0] clr_addr_q, clr_addr_d;

  logic [15:0]           mem_q [MemDepth];
  logic [15:0]           rdata_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [MemAddrBits-1:0] mem_addr;
  logic [15:0]           mem_wdata;

  logic [15:0]           ld_addr16;
  logic [15:0]           src_sum16;
  logic [15:0]           dst_sum16;
  logic [15:0]           host_addr16;
  logic [15:0]           pc_inc;

  assign ld_addr16   = {8'b0, cmd_i.addr};
  assign src_sum16   = {10'b0, cmd_i.src} + offset_q;
  assign dst_sum16   = {9'b0, cur_q.dst} + offset_q;
  assign host_addr16 = {6'b0, cur_q.host_addr};
  assign pc_inc      = pc_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      acc_q      <= '0;
      pc_q       <= '0;
      phase_q    <= 1'b0;
      held_q     <= '0;
      offset_q   <= '0;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      pc_q       <= pc_d;
      phase_q    <= phase_d;
      held_q     <= held_d;
      offset_q   <= offset_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // single-port word memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    acc_d      = acc_q;
    pc_d       = pc_q;
    phase_d    = phase_q;
    held_d     = held_q;
    offset_d   = offset_q;
    clr_addr_d = clr_addr_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = clr_addr_q;
    mem_wdata  = '0;
    cmd_take_o = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        mem_we     = 1'b1;
        clr_addr_d = clr_addr_q + MemAddrBits'(1);
        if (clr_addr_q == {MemAddrBits{1'b1}}) begin
          state_d = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        mem_re   = 1'b1;
        mem_addr = (cmd_i.act == ACT_COPY) ? src_sum16[MemAddrBits-1:0]
                                           : ld_addr16[MemAddrBits-1:0];
        if (cmd_avail_i && !res_full_i) begin
          cmd_take_o = 1'b1;
          cur_d      = cmd_i;
          state_d    = BK_EXEC;
        end
      end
      BK_EXEC: begin
        res_push_o = 1'b1;
        state_d    = BK_ISSUE;
        unique case (cur_q.act)
          ACT_LOAD: begin
            acc_d = rdata_q;
            pc_d  = pc_inc;
          end
          ACT_ADD: begin
            acc_d = acc_q + rdata_q;
            pc_d  = pc_inc;
          end
          ACT_STORE: begin
            mem_we    = 1'b1;
            mem_addr  = MemAddrBits'(cur_q.addr);
            mem_wdata = acc_q;
            pc_d      = pc_inc;
          end
          ACT_BRZ: begin
            pc_d = (acc_q == 16'd0) ? {8'b0, cur_q.addr} : pc_inc;
          end
          ACT_COPY: begin
            if (!phase_q) begin
              mem_we    = 1'b1;
              mem_addr  = dst_sum16[MemAddrBits-1:0];
              mem_wdata = rdata_q;
              held_d    = rdata_q;
              phase_d   = 1'b1;
            end else begin
              if (held_q == 16'd0) begin
                offset_d = '0;
                pc_d     = pc_inc;
              end else begin
                offset_d = offset_q + 16'd1;
              end
              phase_d = 1'b0;
            end
          end
          ACT_HOST: begin
            mem_we    = 1'b1;
            mem_addr  = host_addr16[MemAddrBits-1:0];
            mem_wdata = cur_q.host_data;
          end
          default: begin
          end
        endcase
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    res_word_o.prog_counter = pc_d;
    res_word_o.accum        = acc_d;
    res_word_o.copy_phase   = phase_d;
    res_word_o.copy_offset  = offset_d;
  end

  assign status_o.clearing = (state_q == BK_CLEAR);
  assign status_o.issue    = cmd_take_o;

endmodule

`default_nettype wire

// ===== hdl/acs_resq.sv =====
`default_nettype none

module acs_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  acs_pkg::out_word_t word_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output acs_pkg::out_word_t word_o
);
  import acs_pkg::*;

  out_word_t           q_q [ResqDepth];
  logic [ResqPtrW-1:0] wr_ptr_q;
  logic [ResqPtrW-1:0] rd_ptr_q;
  logic [ResqCntW-1:0] cnt_q;
  logic                do_pop;

  assign full_o  = (cnt_q == ResqCntW'(ResqDepth));
  assign empty_o = (cnt_q == '0);
  assign word_o  = q_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + ResqCntW'(push_i) - ResqCntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/accumulator_cpu_with_strcpy.sv =====
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------------
// input     | push / full          | in_word_i  : kind, instr, host_addr, host_data
// result    | empty / pop          | out_word_o : prog_counter, accum, copy_phase,
//           |                      |              copy_offset
//
// in the execute stage every word passes an issue state, which reads the single-port
// word memory, then an execute state, which updates state and writes the memory back
// the back side takes a new command only once the previous one has executed
// after reset all 2^MEM_ADDR_BITS words of the memory are swept to zero (1024 by
// default), with full held high until the sweep ends
// a two-deep command queue and a two-deep result queue let either side stall
// without stopping the other
`default_nettype none

module accumulator_cpu_with_strcpy #(
  parameter int MEM_ADDR_BITS = acs_pkg::MemAddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  acs_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output acs_pkg::out_word_t out_word_o
);
  import acs_pkg::*;

  // front side: decode into the command queue
  logic         in_accept;
  logic         front_full;
  logic         cmd_avail;
  logic         cmd_take;
  cmd_t         cmd;

  // back side: execute and results
  logic         res_full;
  logic         res_push;
  out_word_t    res_word;
  back_status_t back_st;

  // no words taken while the memory sweep runs
  assign full      = front_full || back_st.clearing;
  assign in_accept = push && !full;

  acs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_accept),
    .in_word_i (in_word_i),
    .full_o    (front_full),
    .take_i    (cmd_take),
    .avail_o   (cmd_avail),
    .cmd_o     (cmd)
  );

  // accumulator, pc, copy state and the word memory live here
  acs_back #(
    .MemAddrBits (MEM_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_avail_i (cmd_avail),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_word_o  (res_word),
    .status_o    (back_st)
  );

  // result queue decouples execute from the consumer
  acs_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .word_i  (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  // a command taken by the back side yields its result the next cycle
  a_issue_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.issue |=> res_push)
    else $error("taken command gave no result");

  // execute never pushes into a full result queue
  a_resq_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // the memory sweep blocks input and produces nothing
  a_clear_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.clearing |-> (full && !res_push && !back_st.issue))
    else $error("activity during memory sweep");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import acs_pkg::*;

  localparam int AddrBits   = MemAddrBitsDef;
  localparam int MemWords   = 1 << AddrBits;
  localparam int CopySteps  = 200;
  localparam int RandomWords = 770;
  localparam int CycleLimit = 400_000;
  // the three opcodes that leave the machine untouched
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_word_t  in_word = '0;
  logic      full;
  logic      empty;
  out_word_t out_word;

  // shadow machine, advanced once per accepted input word
  logic [15:0] cpu_acc = '0;
  logic [15:0] cpu_pc = '0;
  logic [15:0] cpu_mem [MemWords];
  logic        cpu_phase = 1'b0;
  logic [15:0] cpu_held = '0;
  logic [15:0] cpu_ofs = '0;

  in_word_t  program_q [$];    // words waiting to be pushed
  out_word_t cpu_state_q [$];  // machine state predicted for each accepted word

  int mismatches = 0;
  int words_in   = 0;
  int issued     = 0;
  int cycles     = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  accumulator_cpu_with_strcpy dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // word memory index: 16-bit sum of base and offset, wrapped to the memory size
  function automatic logic [AddrBits-1:0] mem_slot(logic [15:0] base, logic [15:0] ofs);
    logic [15:0] sum;
    sum = base + ofs;
    return sum[AddrBits-1:0];
  endfunction

  // advance the shadow machine by one word and return the state it reports
  function automatic out_word_t execute_word(in_word_t w);
    logic [2:0]  op;
    logic [7:0]  addr;
    logic [5:0]  src;
    logic [6:0]  dst;
    logic [15:0] ch;
    out_word_t   st;
    op   = w.instr[2:0];
    addr = w.instr[15:8];
    src  = w.instr[8:3];
    dst  = w.instr[15:9];
    if (w.kind == KIND_HOST) begin
      // host write touches nothing but the one memory word
      cpu_mem[mem_slot(16'(w.host_addr), 16'd0)] = w.host_data;
    end else begin
      case (op)
        OP_LOAD: begin
          cpu_acc = cpu_mem[mem_slot(16'(addr), 16'd0)];
          cpu_pc  = cpu_pc + 16'd1;
        end
        OP_ADD: begin
          cpu_acc = cpu_acc + cpu_mem[mem_slot(16'(addr), 16'd0)];
          cpu_pc  = cpu_pc + 16'd1;
        end
        OP_STORE: begin
          cpu_mem[mem_slot(16'(addr), 16'd0)] = cpu_acc;
          cpu_pc = cpu_pc + 16'd1;
        end
        OP_BRZ: begin
          cpu_pc = (cpu_acc == 16'd0) ? 16'(addr) : cpu_pc + 16'd1;
        end
        OP_COPY: begin
          if (!cpu_phase) begin
            // load-store half: move one word, keep it for the check half
            ch = cpu_mem[mem_slot(16'(src), cpu_ofs)];
            cpu_mem[mem_slot(16'(dst), cpu_ofs)] = ch;
            cpu_held  = ch;
            cpu_phase = 1'b1;
          end else begin
            // check half: a zero word ends the copy and moves the pc on
            if (cpu_held == 16'd0) begin
              cpu_ofs = 16'd0;
              cpu_pc  = cpu_pc + 16'd1;
            end else begin
              cpu_ofs = cpu_ofs + 16'd1;
            end
            cpu_phase = 1'b0;
          end
        end
        default: ;
      endcase
    end
    st.prog_counter = cpu_pc;
    st.accum        = cpu_acc;
    st.copy_phase   = cpu_phase;
    st.copy_offset  = cpu_ofs;
    return st;
  endfunction

  function automatic logic [15:0] mem_instr(logic [2:0] op, logic [7:0] addr);
    return {addr, 5'b0, op};
  endfunction

  function automatic logic [15:0] copy_word(logic [5:0] src, logic [6:0] dst);
    return {dst, src, OP_COPY};
  endfunction

  // random instruction with random filler bits; the copy opcode only on request
  function automatic logic [15:0] any_instr(bit with_copy);
    logic [2:0] op;
    op = 3'($urandom_range(0, 6));
    if (!with_copy && op >= OP_COPY) op = op + 3'd1;
    else if (with_copy && $urandom_range(0, 7) == 0) op = OP_SPARE7;
    return {8'($urandom), 5'($urandom), op};
  endfunction

  // unused fields of each word get random values, the block must ignore them
  task automatic queue_instr(logic [15:0] ins);
    in_word_t w;
    w.kind      = KIND_EXEC;
    w.instr     = ins;
    w.host_addr = 10'($urandom);
    w.host_data = 16'($urandom);
    program_q.push_back(w);
    issued++;
  endtask

  task automatic queue_host(logic [9:0] addr, logic [15:0] data);
    in_word_t w;
    w.kind      = KIND_HOST;
    w.instr     = 16'($urandom);
    w.host_addr = addr;
    w.host_data = data;
    program_q.push_back(w);
    issued++;
  endtask

  // wait until every queued word has been taken, so the shadow state is current
  task automatic wait_taken();
    while (program_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers the head of program_q, draws an idle gap after every word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : send_side
    int unsigned send_gap;
    bit          send_burst;
    logic        nxt_push;
    in_word_t    nxt_word;
    if (!rst_n) begin
      send_gap   = 0;
      send_burst = 1'b0;
      push    <= 1'b0;
      in_word <= '0;
    end else begin
      nxt_push = push;
      nxt_word = in_word;
      if (push && !full) begin
        // word taken: predict its result right here, in acceptance order
        cpu_state_q.push_back(execute_word(in_word));
        void'(program_q.pop_front());
        words_in <= words_in + 1;
        nxt_push = 1'b0;
        // now and then switch between gappy traffic and back-to-back bursts
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 4);
      end else if (!push && send_gap != 0) begin
        send_gap--;
      end
      if (!nxt_push && send_gap == 0 && program_q.size() != 0) begin
        nxt_push = 1'b1;
        nxt_word = program_q[0];
      end
      push    <= nxt_push;
      in_word <= nxt_word;
    end
  end

  // long hold-off on the result side once the long copy is streaming, so both
  // internal queues fill and full has to push back on the sender
  always @(posedge clk) begin
    if (rst_n && !hold_done && words_in == 200) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: pops results, compares each against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : take_side
    int unsigned pop_gap;
    bit          pop_burst;
    int          words_out;
    logic        nxt_pop;
    out_word_t   want;
    if (!rst_n) begin
      pop_gap   = 0;
      pop_burst = 1'b0;
      words_out = 0;
      pop <= 1'b0;
    end else begin
      nxt_pop = pop;
      if (pop && !empty) begin
        if (cpu_state_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d with nothing predicted: pc %h acc %h phase %b ofs %h",
                     words_out, out_word.prog_counter, out_word.accum,
                     out_word.copy_phase, out_word.copy_offset);
        end else begin
          want = cpu_state_q.pop_front();
          if (out_word !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result word %0d: expected pc %h acc %h phase %b ofs %h",
                       words_out, want.prog_counter, want.accum, want.copy_phase,
                       want.copy_offset);
              $display("  got pc %h acc %h phase %b ofs %h",
                       out_word.prog_counter, out_word.accum,
                       out_word.copy_phase, out_word.copy_offset);
            end
          end
        end
        words_out++;
        nxt_pop = 1'b0;
        if ($urandom_range(0, 63) == 0) pop_burst = !pop_burst;
        pop_gap = pop_burst ? 0 : $urandom_range(0, 4);
      end else if (!pop && pop_gap != 0) begin
        pop_gap--;
      end
      if (!nxt_pop && pop_gap == 0) nxt_pop = 1'b1;
      if (hold_left != 0) nxt_pop = 1'b0;
      pop <= nxt_pop;
    end
  end

  // watchdog, generous against the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed words, one long copy, then random sequences
  // ---------------------------------------------------------------------------
  initial begin
    logic [5:0] src;
    logic [6:0] dst;
    int         len;
    int         tries;
    int         pick;
    int         stop_at;
    for (int i = 0; i < MemWords; i++) cpu_mem[i] = 16'h0000;

    // reset held, then released; the block then sweeps its memory with full high
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes and carry wrap of the accumulator
    queue_host(10'h000, 16'hFFFF);
    queue_host(10'h3FF, 16'h0001);
    queue_instr(mem_instr(OP_LOAD, 8'h00));
    queue_instr(mem_instr(OP_ADD, 8'h00));
    queue_host(10'h0FF, 16'h0002);
    queue_instr(mem_instr(OP_ADD, 8'hFF));
    // branch taken on zero, then not taken
    queue_instr(mem_instr(OP_BRZ, 8'hAB));
    queue_instr(mem_instr(OP_STORE, 8'h80));
    queue_instr(mem_instr(OP_LOAD, 8'h00));
    queue_instr(mem_instr(OP_BRZ, 8'h11));
    // spare opcodes change nothing
    queue_instr({13'h1FFF, OP_SPARE5});
    queue_instr({13'h0000, OP_SPARE6});
    queue_instr({13'h1FFF, OP_SPARE7});
    // two-word string plus terminator, with a load slipped into the check half
    queue_host(10'h001, 16'h0041);
    queue_host(10'h002, 16'h0042);
    queue_instr(copy_word(6'd1, 7'd100));
    queue_instr(mem_instr(OP_LOAD, 8'd100));
    repeat (5) queue_instr(copy_word(6'd1, 7'd100));
    queue_instr(16'h0000);
    // empty string at the highest source and destination
    queue_instr(copy_word(6'h3F, 7'h7F));
    queue_instr(copy_word(6'h3F, 7'h7F));

    // self-feeding copy: destination one past source, so the word keeps
    // propagating over a long run of steps; a zero planted at the next read
    // address ends it
    queue_host(10'h000, 16'($urandom_range(1, 65535)));
    repeat (CopySteps) begin
      queue_instr(copy_word(6'd0, 7'd1));
      queue_instr(copy_word(6'd0, 7'd1));
    end
    queue_host(mem_slot(16'd0, 16'(CopySteps)), 16'h0000);
    queue_instr(copy_word(6'd0, 7'd1));
    queue_instr(copy_word(6'd0, 7'd1));

    stop_at = issued + RandomWords;
    while (issued < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // well-formed string copy of random length and content
        src = 6'($urandom);
        dst = 7'($urandom);
        len = $urandom_range(0, 6);
        wait_taken();
        if (cpu_phase) begin
          queue_instr(copy_word(src, dst));
          wait_taken();
        end
        for (int i = 0; i < len; i++)
          queue_host(mem_slot(16'(src), cpu_ofs + 16'(i)), 16'($urandom_range(1, 65535)));
        queue_host(mem_slot(16'(src), cpu_ofs + 16'(len)), 16'h0000);
        for (int i = 0; i <= len; i++) begin
          queue_instr(copy_word(src, dst));
          if ($urandom_range(0, 3) == 0) queue_instr(any_instr(1'b0));
          queue_instr(copy_word(src, dst));
        end
        // overlap or a stray store can stretch or cut the copy: finish it off
        wait_taken();
        tries = 0;
        while (cpu_phase || cpu_ofs != 16'd0) begin
          tries++;
          if (tries > 6 && !cpu_phase) queue_host(mem_slot(16'(src), cpu_ofs), 16'h0000);
          queue_instr(copy_word(src, dst));
          wait_taken();
        end
      end else if (pick < 9) begin
        // mixed arithmetic and host writes, addresses biased low to hit data
        repeat ($urandom_range(4, 12)) begin
          if ($urandom_range(0, 3) == 0)
            queue_host($urandom_range(0, 1) ? 10'($urandom_range(0, 255)) : 10'($urandom),
                       $urandom_range(0, 7) == 0 ? 16'h0000 : 16'($urandom));
          else
            queue_instr(any_instr(1'b1));
        end
      end else begin
        // raw noise words, every field fully random
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) queue_instr(16'($urandom));
          else queue_host(10'($urandom), 16'($urandom));
        end
      end
    end

    // drain, then allow a few cycles for any stray extra result
    while (program_q.size() != 0 || cpu_state_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
